>>> rtl/bdc_pkg.sv
package bdc_pkg;

  localparam int CLOCK_W    = 29;
  localparam int BAUD_W     = 26;
  localparam int MANT_OUT_W = 12;
  localparam int FRAC_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  // 2*clock + baud reaches past 2^30 with a full-scale clock register
  localparam int NUM1_W     = 31;

  localparam logic [CLOCK_W-1:0] CLOCK_RESET = CLOCK_W'(16000000);

  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVS8     = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_BAUD = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

endpackage

>>> rtl/bdc_div_cell.sv
// One restoring-division step: brings down one numerator bit, yields one quotient bit.
module bdc_div_cell #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic          up_valid,
  input  logic [DW-1:0] up_rem,
  input  logic [NW-1:0] up_num,
  input  logic [NW-1:0] up_quo,
  input  logic [DW-1:0] up_den,
  input  logic [SW-1:0] up_side,
  output logic          valid,
  output logic [DW-1:0] rem,
  output logic [NW-1:0] num,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] den,
  output logic [SW-1:0] side
);

  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   diff;
  logic [DW-1:0] rem_next;

  always_comb begin
    trial    = {up_rem, up_num[NW-1]};
    ge       = trial >= {1'b0, up_den};
    diff     = trial - {1'b0, up_den};
    rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rem  <= rem_next;
      num  <= {up_num[NW-2:0], 1'b0};
      quo  <= {up_quo[NW-2:0], ge};
      den  <= up_den;
      side <= up_side;
    end
  end

endmodule

>>> rtl/bdc_div_pipe.sv
// Row of division cells, one quotient bit per cell; empty slots close up.
module bdc_div_pipe #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          v    [0:NW];
  logic [DW-1:0] r    [0:NW];
  logic [NW-1:0] n    [0:NW];
  logic [NW-1:0] q    [0:NW];
  logic [DW-1:0] d    [0:NW];
  logic [SW-1:0] s    [0:NW];
  logic          rdy  [0:NW];

  assign v[0] = in_valid;
  assign r[0] = '0;
  assign n[0] = in_num;
  assign q[0] = '0;
  assign d[0] = in_den;
  assign s[0] = in_side;
  assign rdy[NW] = !out_stall;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    assign rdy[i] = !v[i+1] || rdy[i+1];

    bdc_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .take     (rdy[i]),
      .up_valid (v[i]),
      .up_rem   (r[i]),
      .up_num   (n[i]),
      .up_quo   (q[i]),
      .up_den   (d[i]),
      .up_side  (s[i]),
      .valid    (v[i+1]),
      .rem      (r[i+1]),
      .num      (n[i+1]),
      .quo      (q[i+1]),
      .den      (d[i+1]),
      .side     (s[i+1])
    );
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v[NW];
  assign out_quo   = q[NW];
  assign out_side  = s[NW];

endmodule

>>> rtl/uart_baud_divider_calc.sv
// Fractional baud divider calculator. Each item is a requested baud rate; the
// result is the divider mantissa and fraction (sixteenths, or eighths in
// eight-times oversampling) for the configured peripheral clock, the baud rate
// that divider really gives (truncated), and a status: 0 ok, 1 zero baud,
// 2 mantissa zero or out of range. The divider is rounded half up from
// clock/baud, a rounded fraction carries into the mantissa, and the mantissa
// wraps to MANTISSA_BITS. One item is taken every cycle unless stalled. Items
// pass two rows of restoring-division cells: 31 cells for the rounded divider,
// then 29 cells for the achieved rate. The second row's last cell holds the
// result item; gaps in the rows close up, so new items enter while it waits.
// The user must write configuration with the block idle; it is not enforced.
module uart_baud_divider_calc #(
  parameter int MANTISSA_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bdc_pkg::CLOCK_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bdc_pkg::BAUD_W-1:0]           desired_baud,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bdc_pkg::MANT_OUT_W-1:0]       div_int,
  output logic [bdc_pkg::FRAC_W-1:0]           div_frac,
  output logic [bdc_pkg::CLOCK_W-1:0]          actual_baud,
  output logic [bdc_pkg::STATUS_W-1:0]         result_status
);

  localparam int NUM1_W = bdc_pkg::NUM1_W;
  localparam int DEN1_W = bdc_pkg::BAUD_W + 1;
  localparam int FULL_W = NUM1_W - 3;          // T / 8 is the widest mantissa
  localparam int DIV_W  = MANTISSA_BITS + 4;
  localparam int SIDE2_W = bdc_pkg::STATUS_W + bdc_pkg::MANT_OUT_W + bdc_pkg::FRAC_W + 1;

  // configuration registers
  logic [bdc_pkg::CLOCK_W-1:0] clock_hz;
  logic                        oversample_by_eight;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz            <= bdc_pkg::CLOCK_RESET;
      oversample_by_eight <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bdc_pkg::CFG_CLOCK_HZ: clock_hz            <= cfg_data;
        bdc_pkg::CFG_OVS8:     oversample_by_eight <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // first row: T = (2*clock + baud) / (2*baud), the divider in 1/F units
  logic [NUM1_W-1:0] num1;
  logic [DEN1_W-1:0] den1;
  logic              v1;
  logic              stall1;
  logic [NUM1_W-1:0] t_quo;
  logic              zero_baud;

  assign num1 = NUM1_W'({clock_hz, 1'b0}) + NUM1_W'(desired_baud);
  assign den1 = {desired_baud, 1'b0};

  bdc_div_pipe #(.NW(NUM1_W), .DW(DEN1_W), .SW(1)) u_round_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_num    (num1),
    .in_den    (den1),
    .in_side   (desired_baud == '0),
    .out_valid (v1),
    .out_stall (stall1),
    .out_quo   (t_quo),
    .out_side  (zero_baud)
  );

  // split T into mantissa and fraction; build the emitted divider
  logic [FULL_W-1:0]               full_mant;
  logic [MANTISSA_BITS-1:0]        mant;
  logic [bdc_pkg::FRAC_W-1:0]      frac;
  logic [DIV_W-1:0]                divider;
  bdc_pkg::status_t                status;
  logic                            force_zero;
  logic [SIDE2_W-1:0]              side2;

  always_comb begin
    full_mant = oversample_by_eight ? t_quo[NUM1_W-1:3] : {1'b0, t_quo[NUM1_W-1:4]};
    frac      = oversample_by_eight ? {1'b0, t_quo[2:0]} : t_quo[3:0];
    mant      = full_mant[MANTISSA_BITS-1:0];
    divider   = oversample_by_eight ? {1'b0, mant, t_quo[2:0]} : {mant, t_quo[3:0]};
    if (zero_baud) begin
      status = bdc_pkg::ST_ZERO_BAUD;
    end else if (full_mant == '0 || (full_mant >> MANTISSA_BITS) != '0) begin
      status = bdc_pkg::ST_RANGE;
    end else begin
      status = bdc_pkg::ST_OK;
    end
    force_zero = zero_baud || divider == '0;
    side2 = {status,
             zero_baud ? '0 : bdc_pkg::MANT_OUT_W'(mant),
             zero_baud ? '0 : frac,
             force_zero};
  end

  // second row: clock / divider gives the achieved rate
  logic [bdc_pkg::CLOCK_W-1:0] rate_quo;
  logic [SIDE2_W-1:0]          out_side;

  bdc_div_pipe #(.NW(bdc_pkg::CLOCK_W), .DW(DIV_W), .SW(SIDE2_W)) u_rate_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_stall  (stall1),
    .in_num    (clock_hz),
    .in_den    (divider),
    .in_side   (side2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_quo   (rate_quo),
    .out_side  (out_side)
  );

  assign result_status = out_side[SIDE2_W-1 -: bdc_pkg::STATUS_W];
  assign div_int       = out_side[bdc_pkg::FRAC_W+1 +: bdc_pkg::MANT_OUT_W];
  assign div_frac      = out_side[1 +: bdc_pkg::FRAC_W];
  assign actual_baud   = out_side[0] ? '0 : rate_quo;

  // zero baud must leave all numeric fields clear
  a_zero_baud: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_status == bdc_pkg::ST_ZERO_BAUD
      |-> div_int == '0 && div_frac == '0 && actual_baud == '0)
    else $error("zero-baud result carries data");

  // status never takes the unused code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_status <= bdc_pkg::ST_RANGE)
    else $error("bad status code");

  // in eight-times mode the fraction stays below 8
  a_frac_ovs8: assert property (@(posedge clk) disable iff (rst)
    out_valid && oversample_by_eight |-> !div_frac[3])
    else $error("fraction overflow in 8x mode");

  // a held result item must not move while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(actual_baud) && $stable(result_status))
    else $error("stalled result changed");

endmodule
